### src/b2d_pkg.sv
package b2d_pkg;

    // Value width and decimal digit storage
    localparam int VALUE_WIDTH = 32;
    localparam int NDIGITS     = 10;
    localparam int BCD_W       = NDIGITS * 4;
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    // Terminator code in a digit slot
    localparam logic [3:0] TERM_NIBBLE = 4'hF;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [7:0]             max_digits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_code;
        logic       code_valid;
        logic       last;
        logic [3:0] digit_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

endpackage

### src/b2d_dabble.sv
module b2d_dabble import b2d_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [BCD_W-1:0]       o_bcd
);

    logic [VALUE_WIDTH-1:0] r_shift;
    logic [BCD_W-1:0]       r_bcd;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;
    logic [BCD_W-1:0]       w_adj;
    logic                   w_last_step;

    // Add 3 to every digit of five or more, all digits side by side
    always_comb begin
        for (int i = 0; i < NDIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    assign w_last_step = (r_step == STEP_W'(VALUE_WIDTH - 1));

    // Sequencer: one shift step per cycle, VALUE_WIDTH steps per conversion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (w_last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, shift the top value bit into the digits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_bcd   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_WIDTH-2:0], 1'b0};
            r_bcd   <= {w_adj[BCD_W-2:0], r_shift[VALUE_WIDTH-1]};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

### src/binary_to_decimal_digits.sv
// Each item is loaded into the single dabble unit and converted there in 32 shift-add-3
// steps; the digit string is then sized and registered, then results go to the output register.
// Results then leave at one per cycle when not stalled, 1 to 11 per item.
// Input is ready again only after the last result of an item is loaded.
// Reset (synchronous, active low) clears the sequencer, output valid and the packing mode.
module binary_to_decimal_digits import b2d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    t_state     r_state, n_state;
    logic       r_packed;
    logic [7:0] r_limit;
    logic [3:0] r_ndig, n_ndig;
    logic [3:0] r_count, n_count;
    logic [3:0] r_nres, n_nres;
    logic [3:0] r_emit;
    logic       r_out_valid;
    t_out_item  r_out;

    logic             w_accept;
    logic             w_emit_go;
    logic             w_busy;
    logic             w_done;
    logic [BCD_W-1:0] w_bcd;
    logic [3:0]       w_nseq;
    logic             w_last;
    logic [3:0]       w_hi;
    logic [3:0]       w_lo;
    t_out_item        w_res;

    // Nibble at a position of the emitted string: digit or terminator
    function automatic logic [3:0] seq_nib(input logic [BCD_W-1:0] bcd,
                                           input logic [3:0] ndig,
                                           input logic [3:0] count,
                                           input logic [4:0] pos);
        logic [3:0] idx;
        idx = ndig - 4'd1 - pos[3:0];
        if (pos < {1'b0, count}) begin
            seq_nib = bcd[{idx, 2'b00} +: 4];
        end else begin
            seq_nib = TERM_NIBBLE;
        end
    endfunction

    assign w_accept = i_in_valid && o_in_ready;

    b2d_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_in_data.value),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    // Size the digit string once the conversion is done
    always_comb begin
        n_ndig = 4'd1;
        for (int i = 0; i < NDIGITS; i++) begin
            if (w_bcd[i*4 +: 4] != 4'd0) begin
                n_ndig = 4'(i + 1);
            end
        end
        if (r_limit < {4'd0, n_ndig}) begin
            n_count = r_limit[3:0];
        end else begin
            n_count = n_ndig;
        end
        w_nseq = n_count + 4'({4'd0, n_count} < r_limit);
        if (r_limit == 8'd0) begin
            n_nres = 4'd1;
        end else if (r_packed) begin
            n_nres = 4'((5'(w_nseq) + 5'd1) >> 1);
        end else begin
            n_nres = w_nseq;
        end
    end

    // Build the result at the emit index
    always_comb begin
        w_last = (r_emit + 4'd1 == r_nres);
        w_hi   = seq_nib(w_bcd, r_ndig, r_count, {r_emit, 1'b0});
        w_lo   = seq_nib(w_bcd, r_ndig, r_count, {r_emit, 1'b1});
        w_res.last        = w_last;
        w_res.digit_count = r_count;
        if (r_limit == 8'd0) begin
            w_res.out_code   = 8'd0;
            w_res.code_valid = 1'b0;
        end else if (r_packed) begin
            w_res.out_code   = {w_hi, w_lo};
            w_res.code_valid = 1'b1;
        end else begin
            w_res.out_code   = {4'd0, seq_nib(w_bcd, r_ndig, r_count, {1'b0, r_emit})};
            w_res.code_valid = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CONV;
            end
            S_CONV: begin
                if (w_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit_go && w_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_emit_go  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_CONV:  ;
            S_EMIT:  w_emit_go = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_packed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_emit      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_packed <= i_cfg_data;
            end
            if (w_emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_emit <= '0;
            end else if (w_emit_go) begin
                r_emit <= r_emit + 4'd1;
            end
        end
    end

    // Payload registers: hold the limit, string sizes and the output result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_limit <= i_in_data.max_digits;
        end
        if (r_state == S_CONV && w_done) begin
            r_ndig  <= n_ndig;
            r_count <= n_count;
            r_nres  <= n_nres;
        end
        if (w_emit_go) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The emit index never runs past the result count
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit < r_nres))
        else $error("emit index past result count");

    // A finished conversion moves straight to emission
    a_conv_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && w_done) |=> (r_state == S_EMIT))
        else $error("conversion done but not emitting");

    // The dabble unit is idle while results are emitted
    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !w_busy)
        else $error("dabble unit busy during emission");

endmodule

### verif/digit_stream_checker.sv
`timescale 1ns / 100ps

module digit_stream_checker import b2d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);

    t_out_item expected_codes[$];
    t_out_item want;
    logic      packed_mode   = 1'b0;
    int        fail_count    = 0;
    int        pending_count = 0;
    int        result_count  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        fail_count++;
    endtask

    // Expand one value into the digit, terminator or packed byte stream it should give
    task automatic predict_digit_codes(input logic [31:0] value, input logic [7:0] limit);
        logic [3:0]  digits [NDIGITS];
        logic [3:0]  seq [NDIGITS + 1];
        logic [31:0] rest;
        logic [3:0]  lo;
        int          ndig;
        int          count;
        int          nseq;
        int          nbytes;
        t_out_item   item;
        // Zero limit: one empty result
        if (limit == 8'd0) begin
            item.out_code    = 8'h00;
            item.code_valid  = 1'b0;
            item.last        = 1'b1;
            item.digit_count = 4'd0;
            expected_codes.push_back(item);
            return;
        end
        rest = value;
        for (int i = 0; i < NDIGITS; i++) begin
            digits[i] = 4'(rest % 10);
            rest      = rest / 10;
        end
        // Highest nonzero digit sets the length; zero still has one digit
        ndig = 1;
        for (int i = 0; i < NDIGITS; i++) begin
            if (digits[i] != 4'd0) ndig = i + 1;
        end
        count = (ndig < int'(limit)) ? ndig : int'(limit);
        for (int i = 0; i < count; i++) seq[i] = digits[ndig - 1 - i];
        nseq = count;
        // Terminate only when the limit was not reached
        if (count < int'(limit)) begin
            seq[nseq] = TERM_NIBBLE;
            nseq++;
        end
        item.code_valid  = 1'b1;
        item.digit_count = 4'(count);
        if (!packed_mode) begin
            for (int i = 0; i < nseq; i++) begin
                item.out_code = {4'h0, seq[i]};
                item.last     = (i == nseq - 1);
                expected_codes.push_back(item);
            end
        end else begin
            nbytes = (nseq + 1) / 2;
            for (int i = 0; i < nbytes; i++) begin
                // Fill a missing low nibble of the final byte
                if (2 * i + 1 < nseq) lo = seq[2 * i + 1];
                else lo = TERM_NIBBLE;
                item.out_code = {seq[2 * i], lo};
                item.last     = (i == nbytes - 1);
                expected_codes.push_back(item);
            end
        end
    endtask

    // Compare each output transfer against the oldest prediction, then queue new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            packed_mode = 1'b0;
            expected_codes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with nothing expected", i_out_data));
                end else begin
                    want = expected_codes.pop_front();
                    if (i_out_data.out_code !== want.out_code)
                        report_mismatch($sformatf("out_code got 0x%0h want 0x%0h",
                                                  i_out_data.out_code, want.out_code));
                    if (i_out_data.code_valid !== want.code_valid)
                        report_mismatch($sformatf("code_valid got %0b want %0b",
                                                  i_out_data.code_valid, want.code_valid));
                    if (i_out_data.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  i_out_data.last, want.last));
                    if (i_out_data.digit_count !== want.digit_count)
                        report_mismatch($sformatf("digit_count got %0d want %0d",
                                                  i_out_data.digit_count, want.digit_count));
                end
                result_count++;
            end
            if (i_in_valid && i_in_ready)
                predict_digit_codes(i_in_data.value, i_in_data.max_digits);
            if (i_cfg_we) packed_mode = i_cfg_data;
        end
        pending_count = expected_codes.size();
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import b2d_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 60;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_ready;
    t_in_item     in_data   = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    t_out_item    out_data;
    logic         cfg_we    = 1'b0;
    logic         cfg_data  = 1'b0;
    int           fail_count;
    int           pending_count;
    int           cycle_count = 0;
    t_stall_style stall_style = STALL_NONE;
    int           stall_timer = 0;

    binary_to_decimal_digits u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    digit_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_to_decimal_digits regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure: switch style at random intervals
    always @(negedge clk) begin
        if (stall_timer == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_timer <= $urandom_range(50, 300);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_style)
            STALL_NONE:     out_ready <= 1'b1;
            STALL_COIN:     out_ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_ready <= (cycle_count[2:0] < 3'd3);
            default:        out_ready <= 1'b1;
        endcase
    end

    // Present one item and hold it until the transfer; valid stays high on return
    task automatic send_item(input logic [31:0] v, input logic [7:0] m);
        @(negedge clk);
        in_valid         <= 1'b1;
        in_data.value      <= v;
        in_data.max_digits <= m;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic drain_results(input int tail);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Bursts of mixed values with random gaps, pausing once midway for a full drain
    task automatic run_random(input int items);
        int          sent;
        int          burst;
        int          gap;
        logic [31:0] v;
        logic [31:0] p;
        logic [7:0]  m;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < items; k++) begin
                case ($urandom_range(0, 4))
                    0: v = $urandom_range(0, 9);
                    1: v = $urandom & ((32'h1 << $urandom_range(1, 31)) - 32'h1);
                    2: begin
                        p = 32'd1;
                        repeat ($urandom_range(0, 9)) p = p * 10;
                        v = p - $urandom_range(0, 1);
                    end
                    default: v = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0:       m = 8'($urandom_range(0, 255));
                    1:       m = 8'd0;
                    default: m = 8'($urandom_range(1, 12));
                endcase
                send_item(v, m);
                sent++;
                if (sent == items / 2) drain_results(0);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
            if (gap > 0) idle_gap(gap);
        end
    endtask

    initial begin
        // Hold reset low at the start, then release it
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // One digit per result
        write_mode(1'b0);
        send_item(32'd0, 8'd1);
        send_item(32'd0, 8'd0);
        send_item(32'd1, 8'd5);
        send_item(32'd9, 8'd1);
        send_item(32'd10, 8'd2);
        send_item(32'd99, 8'd3);
        send_item(32'hFFFF_FFFF, 8'd10);
        send_item(32'hFFFF_FFFF, 8'd11);
        send_item(32'hFFFF_FFFF, 8'd255);
        send_item(32'd1000000000, 8'd4);
        send_item(32'd12345, 8'd0);
        drain_results(SETTLE);

        // Two digits per byte
        write_mode(1'b1);
        send_item(32'd0, 8'd1);
        send_item(32'd0, 8'd2);
        send_item(32'd12345, 8'd5);
        send_item(32'd12345, 8'd6);
        send_item(32'd98, 8'd1);
        send_item(32'd7, 8'd0);
        send_item(32'hFFFF_FFFF, 8'd10);
        send_item(32'hFFFF_FFFE, 8'd128);
        send_item(32'd1000000000, 8'd11);
        drain_results(SETTLE);

        write_mode(1'b0);
        run_random(50);
        drain_results(SETTLE);
        write_mode(1'b1);
        run_random(50);
        drain_results(SETTLE);
        write_mode(1'b0);
        run_random(30);
        drain_results(SETTLE);
        write_mode(1'b1);
        run_random(30);
        drain_results(SETTLE);

        if (fail_count == 0 && pending_count == 0) begin
            $display("binary_to_decimal_digits regression: pass");
        end else begin
            $display("binary_to_decimal_digits regression: fail");
        end
        $finish;
    end

endmodule

### binary_to_decimal_digits.f
src/b2d_pkg.sv
src/b2d_dabble.sv
src/binary_to_decimal_digits.sv
verif/digit_stream_checker.sv
verif/testbench.sv
